// ===== design/bes_pkg.sv =====
`timescale 1ns / 1ps

package bes_pkg;

    // Point and utility width (signed Q16.16)
    localparam int POINT_W      = 32;
    localparam int FUNC_W       = 2;
    localparam int KIND_W       = 2;
    localparam int COUNT_W      = 16;
    localparam int STEP_CFG_W   = 31;
    localparam int CFG_DATA_W   = 31;

    // Bracket expansion limit
    localparam int MAX_EXPAND   = 100;
    localparam int EXP_CNT_W    = $clog2(MAX_EXPAND + 1);

    // Input commands
    typedef enum logic [FUNC_W-1:0] {
        FUNC_START_POINT  = 2'd0,
        FUNC_START_BOUNDS = 2'd1,
        FUNC_REPLY        = 2'd2,
        FUNC_REFINE       = 2'd3
    } t_func;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_EVAL   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // Configuration register indexes
    typedef enum logic {
        CFG_MAXIMIZE     = 1'b0,
        CFG_INITIAL_STEP = 1'b1
    } t_cfg_idx;

endpackage

// ===== design/bes_in_if.sv =====
`timescale 1ns / 1ps

// Command / utility reply channel
interface bes_in_if;
    logic                                valid;
    logic                                ready;
    logic        [bes_pkg::FUNC_W-1:0]   func;
    logic signed [bes_pkg::POINT_W-1:0]  first_point;
    logic signed [bes_pkg::POINT_W-1:0]  second_point;
    logic signed [bes_pkg::POINT_W-1:0]  utility_value;

    modport source (
        output valid, func, first_point, second_point, utility_value,
        input  ready
    );
    modport sink (
        input  valid, func, first_point, second_point, utility_value,
        output ready
    );
endinterface

// ===== design/bes_out_if.sv =====
`timescale 1ns / 1ps

// Query / status channel
interface bes_out_if;
    logic                                valid;
    logic                                ready;
    logic        [bes_pkg::KIND_W-1:0]   kind;
    logic signed [bes_pkg::POINT_W-1:0]  query_point;
    logic signed [bes_pkg::POINT_W-1:0]  best_point;
    logic signed [bes_pkg::POINT_W-1:0]  best_utility;
    logic signed [bes_pkg::POINT_W-1:0]  lower_bound;
    logic signed [bes_pkg::POINT_W-1:0]  upper_bound;
    logic        [bes_pkg::COUNT_W-1:0]  refine_count;

    modport source (
        output valid, kind, query_point, best_point, best_utility,
               lower_bound, upper_bound, refine_count,
        input  ready
    );
    modport sink (
        input  valid, kind, query_point, best_point, best_utility,
               lower_bound, upper_bound, refine_count,
        output ready
    );
endinterface

// ===== design/bracketed_1d_extremum_search.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// i_in      in   valid / ready      func, first_point, second_point, utility_value
// o_out     out  valid / ready      kind, query_point, best_point, best_utility,
//                                   lower_bound, upper_bound, refine_count
// i_cfg_*   in   write enable only  index (0 maximize, 1 initial_step), data
//
// The next-state logic (33-bit saturating and averaging adds, compares and muxes)
// sits between the state registers and the result register.
// A new item is taken every cycle while the result register is empty or drained.
// Reset (synchronous, active low) clears the bracket, counters and phase.
// A stall on o_out holds the result and all search state; i_in.ready drops.

module bracketed_1d_extremum_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  bes_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [bes_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bes_in_if.sink                       i_in,
    bes_out_if.source                    o_out
);
    import bes_pkg::*;

    typedef enum logic [3:0] {
        PH_UNINIT = 4'd0,
        PH_READY  = 4'd1,
        PH_PT_X   = 4'd2,
        PH_PT_Y   = 4'd3,
        PH_PT_T   = 4'd4,
        PH_BD_N   = 4'd5,
        PH_BD_M   = 4'd6,
        PH_BD_P   = 4'd7,
        PH_RF_A   = 4'd8,
        PH_RF_B   = 4'd9
    } t_phase;

    localparam logic signed [POINT_W-1:0] PMAX     = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic signed [POINT_W-1:0] PMIN     = {1'b1, {(POINT_W-1){1'b0}}};
    localparam logic signed [POINT_W-1:0] HALF_MAX = PMAX >>> 1;
    localparam logic signed [POINT_W-1:0] NEG_MAX  = -PMAX;
    localparam logic signed [POINT_W-1:0] NEG_HALF = -HALF_MAX;

    // Saturating signed add
    function automatic logic signed [POINT_W-1:0] sat_add(
        input logic signed [POINT_W-1:0] a,
        input logic signed [POINT_W-1:0] b
    );
        logic signed [POINT_W:0] s;
        s = {a[POINT_W-1], a} + {b[POINT_W-1], b};
        if (s[POINT_W] != s[POINT_W-1])
            return s[POINT_W] ? PMIN : PMAX;
        return s[POINT_W-1:0];
    endfunction

    // Floor of the average; always in range
    function automatic logic signed [POINT_W-1:0] mid_of(
        input logic signed [POINT_W-1:0] a,
        input logic signed [POINT_W-1:0] b
    );
        logic signed [POINT_W:0] s;
        s = {a[POINT_W-1], a} + {b[POINT_W-1], b};
        return s[POINT_W:1];
    endfunction

    // Configuration
    logic                  r_maximize;
    logic [STEP_CFG_W-1:0] r_initial_step;

    // Search state
    logic signed [POINT_W-1:0] r_low, r_mid, r_high;
    logic signed [POINT_W-1:0] r_ulow, r_umid, r_uhigh, r_uleft;
    logic signed [POINT_W-1:0] r_step;
    logic [EXP_CNT_W-1:0]      r_cnt;
    t_phase                    r_phase;
    logic [COUNT_W-1:0]        r_steps;

    // Result register
    logic                      r_out_valid;
    t_kind                     r_kind;
    logic signed [POINT_W-1:0] r_query;

    logic signed [POINT_W-1:0] n_low, n_mid, n_high;
    logic signed [POINT_W-1:0] n_ulow, n_umid, n_uhigh, n_uleft;
    logic signed [POINT_W-1:0] n_step;
    logic [EXP_CNT_W-1:0]      n_cnt;
    t_phase                    n_phase;
    logic [COUNT_W-1:0]        n_steps;
    t_kind                     n_kind;
    logic signed [POINT_W-1:0] n_query;

    logic                      in_xfer;
    logic                      fin, fin_copy, probe;
    logic signed [POINT_W-1:0] probe_pt, quarter_a, quarter_b, tmp_pt, tmp_u;
    logic                      a_best, m_best;

    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign quarter_a  = mid_of(r_low, r_mid);
    assign quarter_b  = mid_of(r_mid, r_high);

    // Direction-aware compares for refine
    always_comb begin
        if (r_maximize) begin
            a_best = (r_uleft > r_umid) && (r_uleft > i_in.utility_value);
            m_best = (r_umid > r_uleft) && (r_umid > i_in.utility_value);
        end else begin
            a_best = (r_uleft < r_umid) && (r_uleft < i_in.utility_value);
            m_best = (r_umid < r_uleft) && (r_umid < i_in.utility_value);
        end
    end

    // Next-state logic for one transfer
    always_comb begin
        n_low    = r_low;
        n_mid    = r_mid;
        n_high   = r_high;
        n_ulow   = r_ulow;
        n_umid   = r_umid;
        n_uhigh  = r_uhigh;
        n_uleft  = r_uleft;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        n_steps  = r_steps;
        n_kind   = KIND_REJECT;
        n_query  = '0;
        fin      = 1'b0;
        fin_copy = 1'b0;
        probe    = 1'b0;
        probe_pt = '0;
        tmp_pt   = '0;
        tmp_u    = '0;

        case (t_func'(i_in.func))
            FUNC_START_POINT: begin
                n_low   = i_in.first_point;
                n_step  = {1'b0, r_initial_step};
                n_mid   = sat_add(i_in.first_point, {1'b0, r_initial_step});
                n_cnt   = '0;
                n_phase = PH_PT_X;
                n_kind  = KIND_EVAL;
                n_query = i_in.first_point;
            end
            FUNC_START_BOUNDS: begin
                if (i_in.first_point < i_in.second_point) begin
                    n_low  = i_in.first_point;
                    n_high = i_in.second_point;
                end else begin
                    n_low  = i_in.second_point;
                    n_high = i_in.first_point;
                end
                n_mid   = mid_of(n_low, n_high);
                n_phase = PH_BD_N;
                n_kind  = KIND_EVAL;
                n_query = n_low;
            end
            FUNC_REFINE: begin
                if (r_phase == PH_READY) begin
                    n_phase = PH_RF_A;
                    n_kind  = KIND_EVAL;
                    n_query = quarter_a;
                end
            end
            default: begin
                unique case (r_phase)
                    PH_PT_X: begin
                        n_ulow  = i_in.utility_value;
                        n_phase = PH_PT_Y;
                        n_kind  = KIND_EVAL;
                        n_query = r_mid;
                    end
                    PH_PT_Y: begin
                        n_umid = i_in.utility_value;
                        // Turn round when the second probe is worse
                        if (r_maximize ? (i_in.utility_value < r_ulow)
                                       : (i_in.utility_value > r_ulow)) begin
                            n_low  = r_mid;
                            n_mid  = r_low;
                            n_ulow = i_in.utility_value;
                            n_umid = r_ulow;
                            n_step = -r_step;
                        end
                        probe = 1'b1;
                    end
                    PH_PT_T: begin
                        n_uhigh = i_in.utility_value;
                        if (r_maximize ? (i_in.utility_value < r_umid)
                                       : (i_in.utility_value > r_umid)) begin
                            fin = 1'b1;
                        end else begin
                            n_low  = r_mid;
                            n_ulow = r_umid;
                            n_mid  = r_high;
                            n_umid = i_in.utility_value;
                            // Saturating doubling of the step
                            if (r_step > HALF_MAX)
                                n_step = PMAX;
                            else if (r_step < NEG_HALF)
                                n_step = NEG_MAX;
                            else
                                n_step = r_step <<< 1;
                            n_cnt = r_cnt + 1'b1;
                            if (n_cnt >= EXP_CNT_W'(MAX_EXPAND)) begin
                                fin      = 1'b1;
                                fin_copy = 1'b1;
                            end else begin
                                probe = 1'b1;
                            end
                        end
                    end
                    PH_BD_N: begin
                        n_ulow  = i_in.utility_value;
                        n_phase = PH_BD_M;
                        n_kind  = KIND_EVAL;
                        n_query = r_mid;
                    end
                    PH_BD_M: begin
                        n_umid  = i_in.utility_value;
                        n_phase = PH_BD_P;
                        n_kind  = KIND_EVAL;
                        n_query = r_high;
                    end
                    PH_BD_P: begin
                        n_uhigh = i_in.utility_value;
                        n_phase = PH_READY;
                        n_kind  = KIND_DONE;
                    end
                    PH_RF_A: begin
                        n_uleft = i_in.utility_value;
                        n_phase = PH_RF_B;
                        n_kind  = KIND_EVAL;
                        n_query = quarter_b;
                    end
                    PH_RF_B: begin
                        // Keep the best three of five points
                        if (a_best) begin
                            n_high  = r_mid;
                            n_uhigh = r_umid;
                            n_mid   = quarter_a;
                            n_umid  = r_uleft;
                        end else if (m_best) begin
                            n_low   = quarter_a;
                            n_ulow  = r_uleft;
                            n_high  = quarter_b;
                            n_uhigh = i_in.utility_value;
                        end else begin
                            n_low   = r_mid;
                            n_ulow  = r_umid;
                            n_mid   = quarter_b;
                            n_umid  = i_in.utility_value;
                        end
                        if (r_steps != {COUNT_W{1'b1}})
                            n_steps = r_steps + 1'b1;
                        n_phase = PH_READY;
                        n_kind  = KIND_DONE;
                    end
                    default: begin
                        // Stray reply: no query outstanding
                        n_kind = KIND_REJECT;
                    end
                endcase
            end
        endcase

        // Next expansion probe; stop when it saturates onto the middle
        if (probe) begin
            probe_pt = sat_add(n_mid, n_step);
            if (probe_pt == n_mid) begin
                fin      = 1'b1;
                fin_copy = 1'b1;
            end else begin
                n_high  = probe_pt;
                n_phase = PH_PT_T;
                n_kind  = KIND_EVAL;
                n_query = probe_pt;
            end
        end

        // Close the bracket and order its ends
        if (fin) begin
            if (fin_copy) begin
                n_high  = n_mid;
                n_uhigh = n_umid;
            end
            if (n_low > n_high) begin
                tmp_pt  = n_low;
                tmp_u   = n_ulow;
                n_low   = n_high;
                n_ulow  = n_uhigh;
                n_high  = tmp_pt;
                n_uhigh = tmp_u;
            end
            n_phase = PH_READY;
            n_kind  = KIND_DONE;
            n_query = '0;
        end
    end

    // State, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maximize     <= 1'b0;
            r_initial_step <= STEP_CFG_W'(1);
            r_low          <= '0;
            r_mid          <= '0;
            r_high         <= '0;
            r_ulow         <= '0;
            r_umid         <= '0;
            r_uhigh        <= '0;
            r_uleft        <= '0;
            r_step         <= '0;
            r_cnt          <= '0;
            r_phase        <= PH_UNINIT;
            r_steps        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAXIMIZE:     r_maximize     <= i_cfg_data[0];
                    CFG_INITIAL_STEP: r_initial_step <= i_cfg_data[STEP_CFG_W-1:0];
                    default:          r_maximize     <= r_maximize;
                endcase
            end
            if (in_xfer) begin
                r_low       <= n_low;
                r_mid       <= n_mid;
                r_high      <= n_high;
                r_ulow      <= n_ulow;
                r_umid      <= n_umid;
                r_uhigh     <= n_uhigh;
                r_uleft     <= n_uleft;
                r_step      <= n_step;
                r_cnt       <= n_cnt;
                r_phase     <= n_phase;
                r_steps     <= n_steps;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind  <= n_kind;
            r_query <= n_query;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.query_point  = r_query;
    assign o_out.best_point   = r_mid;
    assign o_out.best_utility = r_umid;
    assign o_out.lower_bound  = r_low;
    assign o_out.upper_bound  = r_high;
    assign o_out.refine_count = r_steps;

`ifndef SYNTHESIS
    // A done result always leaves the block with a usable bracket
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_DONE) |-> (r_phase == PH_READY))
        else $error("done result without ready phase");

    // Query point is only driven for evaluate results
    a_query_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_EVAL) |-> (r_query == '0))
        else $error("nonzero query on non-evaluate result");

    // Bracket ends are ordered whenever a bracket exists
    a_bracket_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_READY) |-> (r_low <= r_high))
        else $error("bracket ends out of order");

    // Refine count never goes backward
    a_steps_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_steps >= $past(r_steps)))
        else $error("refine count decreased");

    // Search state only moves on an input transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(in_xfer)) |-> ($stable(r_phase) && $stable(r_mid)))
        else $error("state changed without a transfer");
`endif

endmodule

// ===== tb/sv/bracketed_1d_extremum_search_tb.sv =====
`timescale 1ns / 1ps

module bracketed_1d_extremum_search_tb;
    import bes_pkg::*;

    localparam longint PT_MAX = (longint'(1) << (POINT_W - 1)) - 1;
    localparam longint PT_MIN = -PT_MAX - 1;
    localparam logic signed [POINT_W-1:0] P32_MAX = 32'sh7fffffff;
    localparam logic signed [POINT_W-1:0] P32_MIN = 32'sh80000000;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int N_PHASES = 6;
    localparam int LONG_HOLD = 60;

    // Search sequencer phases, tracked on the checker side
    typedef enum {
        ST_UNINIT, ST_READY, ST_PT_FIRST, ST_PT_SECOND, ST_PT_PROBE,
        ST_BD_LOW, ST_BD_MID, ST_BD_HIGH, ST_RF_LEFT, ST_RF_RIGHT
    } search_state_e;

    // Shapes of the utility curve the emulated evaluator answers with
    typedef enum {SHAPE_VEE, SHAPE_NOISE, SHAPE_FLAT, SHAPE_RAMP} utility_shape_e;

    typedef struct packed {
        t_func                     func;
        logic signed [POINT_W-1:0] p1;
        logic signed [POINT_W-1:0] p2;
        logic signed [POINT_W-1:0] u;
    } cmd_t;

    typedef struct packed {
        t_kind                     kind;
        logic signed [POINT_W-1:0] query;
        logic signed [POINT_W-1:0] best;
        logic signed [POINT_W-1:0] best_u;
        logic signed [POINT_W-1:0] lo;
        logic signed [POINT_W-1:0] hi;
        logic [COUNT_W-1:0]        count;
    } res_t;

    // Tracks the bracket state and holds the results still owed by the block
    class bracket_tracker;
        bit            maximize;
        longint        init_step = 1;
        longint        lo_pt, mid_pt, hi_pt;
        longint        lo_u, mid_u, hi_u, left_u;
        longint        step;
        int            n_expand;
        search_state_e phase;
        int unsigned   n_refine;
        longint        last_query;
        res_t          pending_results[$];
        int            errors;

        function longint clip(longint v);
            return v > PT_MAX ? PT_MAX : (v < PT_MIN ? PT_MIN : v);
        endfunction

        // floor((a + b) / 2)
        function longint halfway(longint a, longint b);
            longint s;
            s = a + b;
            return clip(s >>> 1);
        endfunction

        function bit improves(longint a, longint b);
            return maximize ? a > b : a < b;
        endfunction

        function bit degrades(longint a, longint b);
            return maximize ? a < b : a > b;
        endfunction

        function void push(t_kind kind, longint q);
            res_t r;
            r.kind   = kind;
            r.query  = q[31:0];
            r.best   = mid_pt[31:0];
            r.best_u = mid_u[31:0];
            r.lo     = lo_pt[31:0];
            r.hi     = hi_pt[31:0];
            r.count  = n_refine[COUNT_W-1:0];
            if (kind == KIND_EVAL) begin
                last_query = q;
            end
            pending_results.push_back(r);
        endfunction

        function void set_config(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MAXIMIZE) begin
                maximize = data[0];
            end else begin
                init_step = longint'(data);
            end
        endfunction

        // End of expansion: order the two ends
        function void close_bracket(bit copy_mid);
            longint t;
            if (copy_mid) begin
                hi_pt = mid_pt;
                hi_u  = mid_u;
            end
            if (lo_pt > hi_pt) begin
                t = lo_pt; lo_pt = hi_pt; hi_pt = t;
                t = lo_u;  lo_u  = hi_u;  hi_u  = t;
            end
            phase = ST_READY;
            push(KIND_DONE, 0);
        endfunction

        function void next_probe();
            longint t;
            t = clip(mid_pt + step);
            if (t == mid_pt) begin
                close_bracket(1'b1);
            end else begin
                hi_pt = t;
                phase = ST_PT_PROBE;
                push(KIND_EVAL, t);
            end
        endfunction

        function void take_reply(longint u);
            longint t, va, vb;
            case (phase)
                ST_PT_FIRST: begin
                    lo_u  = u;
                    phase = ST_PT_SECOND;
                    push(KIND_EVAL, mid_pt);
                end
                ST_PT_SECOND: begin
                    mid_u = u;
                    // turn round when the second probe is worse
                    if (degrades(mid_u, lo_u)) begin
                        t = lo_pt; lo_pt = mid_pt; mid_pt = t;
                        t = lo_u;  lo_u  = mid_u;  mid_u  = t;
                        step = -step;
                    end
                    next_probe();
                end
                ST_PT_PROBE: begin
                    hi_u = u;
                    if (degrades(u, mid_u)) begin
                        close_bracket(1'b0);
                    end else begin
                        lo_pt  = mid_pt; lo_u  = mid_u;
                        mid_pt = hi_pt;  mid_u = u;
                        if (step > PT_MAX / 2) step = PT_MAX;
                        else if (step < -(PT_MAX / 2)) step = -PT_MAX;
                        else step = step * 2;
                        n_expand++;
                        if (n_expand >= MAX_EXPAND) close_bracket(1'b1);
                        else next_probe();
                    end
                end
                ST_BD_LOW: begin
                    lo_u  = u;
                    phase = ST_BD_MID;
                    push(KIND_EVAL, mid_pt);
                end
                ST_BD_MID: begin
                    mid_u = u;
                    phase = ST_BD_HIGH;
                    push(KIND_EVAL, hi_pt);
                end
                ST_BD_HIGH: begin
                    hi_u  = u;
                    phase = ST_READY;
                    push(KIND_DONE, 0);
                end
                ST_RF_LEFT: begin
                    left_u = u;
                    phase  = ST_RF_RIGHT;
                    push(KIND_EVAL, halfway(mid_pt, hi_pt));
                end
                ST_RF_RIGHT: begin
                    va = halfway(lo_pt, mid_pt);
                    vb = halfway(mid_pt, hi_pt);
                    // keep the best three of five; ties go to the right quarter
                    if (improves(left_u, mid_u) && improves(left_u, u)) begin
                        hi_pt  = mid_pt; hi_u  = mid_u;
                        mid_pt = va;     mid_u = left_u;
                    end else if (improves(mid_u, left_u) && improves(mid_u, u)) begin
                        lo_pt = va; lo_u = left_u;
                        hi_pt = vb; hi_u = u;
                    end else begin
                        lo_pt  = mid_pt; lo_u  = mid_u;
                        mid_pt = vb;     mid_u = u;
                    end
                    if (n_refine < 16'hffff) n_refine++;
                    phase = ST_READY;
                    push(KIND_DONE, 0);
                end
                default: push(KIND_REJECT, 0);
            endcase
        endfunction

        function void accept_command(cmd_t c);
            longint p1, p2;
            p1 = $signed(c.p1);
            p2 = $signed(c.p2);
            case (c.func)
                FUNC_START_POINT: begin
                    lo_pt    = p1;
                    step     = init_step;
                    mid_pt   = clip(p1 + step);
                    n_expand = 0;
                    phase    = ST_PT_FIRST;
                    push(KIND_EVAL, lo_pt);
                end
                FUNC_START_BOUNDS: begin
                    lo_pt  = (p1 < p2) ? p1 : p2;
                    hi_pt  = (p1 < p2) ? p2 : p1;
                    mid_pt = halfway(lo_pt, hi_pt);
                    phase  = ST_BD_LOW;
                    push(KIND_EVAL, lo_pt);
                end
                FUNC_REFINE: begin
                    if (phase != ST_READY) begin
                        push(KIND_REJECT, 0);
                    end else begin
                        phase = ST_RF_LEFT;
                        push(KIND_EVAL, halfway(lo_pt, mid_pt));
                    end
                end
                default: take_reply($signed(c.u));
            endcase
        endfunction

        function string show(res_t r);
            return $sformatf("kind %0d query %0d best %0d/%0d bracket %0d..%0d count %0d",
                             r.kind, r.query, r.best, r.best_u, r.lo, r.hi, r.count);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %s", show(got));
                return;
            end
            want = pending_results.pop_front();
            if (want.kind != got.kind || want.query != got.query || want.best != got.best
                || want.best_u != got.best_u || want.lo != got.lo || want.hi != got.hi
                || want.count != got.count) begin
                errors++;
                if (errors <= 10) begin
                    $display("result differs at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bes_in_if  in_ch ();
    bes_out_if out_ch ();

    bracketed_1d_extremum_search uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    bracket_tracker sb;
    bit             no_gaps;
    bit             long_hold_req;
    int unsigned    cycle_count;

    // Evaluator emulation
    utility_shape_e shape;
    longint         target;
    int             shape_shift;
    logic signed [POINT_W-1:0] flat_u;
    bit             ramp_up;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bracketed_1d_extremum_search: mismatch");
            $finish;
        end
    end

    // Transfer monitor on both channels
    always @(posedge i_clk) begin
        res_t got;
        cmd_t c;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.kind   = t_kind'(out_ch.kind);
                got.query  = out_ch.query_point;
                got.best   = out_ch.best_point;
                got.best_u = out_ch.best_utility;
                got.lo     = out_ch.lower_bound;
                got.hi     = out_ch.upper_bound;
                got.count  = out_ch.refine_count;
                sb.check_result(got);
            end
            if (in_ch.valid && in_ch.ready) begin
                c.func = t_func'(in_ch.func);
                c.p1   = in_ch.first_point;
                c.p2   = in_ch.second_point;
                c.u    = in_ch.utility_value;
                sb.accept_command(c);
            end
        end
    end

    // Result receiver with random stalls and one long hold-off
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            if (long_hold_req) begin
                stall = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    function automatic cmd_t mk(t_func f, logic signed [POINT_W-1:0] a,
                                logic signed [POINT_W-1:0] b, logic signed [POINT_W-1:0] u);
        cmd_t c;
        c.func = f;
        c.p1   = a;
        c.p2   = b;
        c.u    = u;
        return c;
    endfunction

    function automatic logic signed [POINT_W-1:0] pick_point();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return P32_MAX - $urandom_range(0, 64);
            2: return P32_MIN + $urandom_range(0, 64);
            default: return $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
    endfunction

    function automatic void pick_shape(longint center);
        shape       = utility_shape_e'($urandom_range(0, 3));
        target      = center + longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        shape_shift = $urandom_range(0, 16);
        flat_u      = $urandom;
        ramp_up     = 1'($urandom_range(0, 1));
    endfunction

    function automatic logic signed [POINT_W-1:0] utility_at(longint x);
        longint d;
        logic signed [POINT_W-1:0] x32;
        x32 = x[31:0];
        case (shape)
            SHAPE_VEE: begin
                // distance to the target, coarsened so that ties occur
                d = x - target;
                if (d < 0) d = -d;
                d = d >>> shape_shift;
                if (d > PT_MAX) d = PT_MAX;
                if (sb.maximize) d = -d;
                return d[31:0];
            end
            SHAPE_NOISE: return $urandom;
            SHAPE_FLAT:  return flat_u;
            default:     return ramp_up ? x32 : ~x32;
        endcase
    endfunction

    // Mostly well-formed search traffic, a little noise
    function automatic cmd_t next_cmd();
        cmd_t c;
        int   r;
        r      = $urandom_range(0, 99);
        c.func = t_func'($urandom_range(0, 3));
        c.p1   = $urandom;
        c.p2   = $urandom;
        c.u    = $urandom;
        if (r < 4) return c;
        if (sb.phase == ST_UNINIT || sb.phase == ST_READY) begin
            if (sb.phase == ST_READY && r < 70) begin
                c.func = FUNC_REFINE;
            end else begin
                c.func = (r % 2) ? FUNC_START_POINT : FUNC_START_BOUNDS;
                c.p1   = pick_point();
                c.p2   = pick_point();
                pick_shape($signed(c.p1));
            end
        end else begin
            c.func = FUNC_REPLY;
            c.u    = utility_at(sb.last_query);
        end
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic put_item(cmd_t c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= c.func;
        in_ch.first_point   <= c.p1;
        in_ch.second_point  <= c.p2;
        in_ch.utility_value <= c.u;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_until_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_config(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        cmd_t                  directed[$];
        bit [N_PHASES-1:0]     max_plan;
        logic [CFG_DATA_W-1:0] step_cfg;
        sb = new();
        max_plan = 6'b011010;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_MAXIMIZE;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.func          = FUNC_REPLY;
        in_ch.first_point   = '0;
        in_ch.second_point  = '0;
        in_ch.utility_value = '0;
        out_ch.ready        = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stray reply, early refine, bounds at the range extremes
        directed.push_back(mk(FUNC_REPLY, 0, 0, 0));
        directed.push_back(mk(FUNC_START_BOUNDS, P32_MAX, P32_MIN, 0));
        directed.push_back(mk(FUNC_REFINE, 0, 0, 0));
        directed.push_back(mk(FUNC_REPLY, 0, 0, P32_MAX));
        directed.push_back(mk(FUNC_REPLY, 0, 0, P32_MIN));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 0));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 7));
        directed.push_back(mk(FUNC_REFINE, 0, 0, 0));
        directed.push_back(mk(FUNC_REPLY, 0, 0, -1));
        directed.push_back(mk(FUNC_REPLY, 0, 0, -1));
        // point start at the top: probe saturates onto the middle
        directed.push_back(mk(FUNC_START_POINT, P32_MAX, 0, 0));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 5));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 5));
        // a start that abandons a search in progress, odd negative sum for the midpoint
        directed.push_back(mk(FUNC_START_POINT, 0, 0, 0));
        directed.push_back(mk(FUNC_START_BOUNDS, -5, 2, 0));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 1));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 2));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 3));
        // turn round, expand once, stop on a worse probe, ends swapped
        directed.push_back(mk(FUNC_START_POINT, 0, 0, 0));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 0));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 7));
        directed.push_back(mk(FUNC_REPLY, 0, 0, -4));
        directed.push_back(mk(FUNC_REPLY, 0, 0, 10));
        directed.push_back(mk(FUNC_REFINE, 0, 0, 0));
        directed.push_back(mk(FUNC_REPLY, 0, 0, P32_MIN));
        directed.push_back(mk(FUNC_REPLY, 0, 0, P32_MAX));
        foreach (directed[i]) put_item(directed[i]);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            idle_until_drained();
            repeat (3) @(negedge i_clk);
            case (ph)
                0: step_cfg = 31'd1;
                1: step_cfg = 31'h7fffffff;
                2: step_cfg = 31'h40000000;
                3: step_cfg = '0;
                4: step_cfg = CFG_DATA_W'($urandom_range(1, 255));
                default: step_cfg = CFG_DATA_W'($urandom);
            endcase
            write_cfg(CFG_MAXIMIZE, CFG_DATA_W'(max_plan[ph]));
            write_cfg(CFG_INITIAL_STEP, step_cfg);
            no_gaps = (ph == 2);
            if (ph == 3) long_hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 4 && k == ITEMS_PER_PHASE / 2) idle_until_drained();
                put_item(next_cmd());
            end
        end

        idle_until_drained();
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("bracketed_1d_extremum_search: match");
        end else begin
            $display("bracketed_1d_extremum_search: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/bes_pkg.sv
design/bes_in_if.sv
design/bes_out_if.sv
design/bracketed_1d_extremum_search.sv
tb/sv/bracketed_1d_extremum_search_tb.sv
